[rtl/alrm_pkg.sv]
// Shared types, codes and BCD helpers for the watch alarm controller.
`default_nettype none

package alrm_pkg;

  localparam logic [2:0] ACT_KEY    = 3'd0;
  localparam logic [2:0] ACT_MODE   = 3'd1;
  localparam logic [2:0] ACT_ADJUST = 3'd2;
  localparam logic [2:0] ACT_BLINK  = 3'd3;
  localparam logic [2:0] ACT_CHIME  = 3'd4;
  localparam logic [2:0] ACT_DAILY  = 3'd5;

  localparam logic [2:0] CMD_NONE         = 3'd0;
  localparam logic [2:0] CMD_ARM_DAILY    = 3'd1;
  localparam logic [2:0] CMD_CANCEL_DAILY = 3'd2;
  localparam logic [2:0] CMD_REPLACE      = 3'd3;
  localparam logic [2:0] CMD_ARM_CHIME    = 3'd4;
  localparam logic [2:0] CMD_CANCEL_CHIME = 3'd5;

  localparam logic [1:0] TONE_SILENT = 2'd0;
  localparam logic [1:0] TONE_CHIME  = 2'd1;
  localparam logic [1:0] TONE_ALARM  = 2'd2;

  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] KEY_FOUR  = 8'h34;
  localparam logic [7:0] KEY_DOT   = 8'h2E;
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;

  localparam logic [5:0] HOUR_RESET   = 6'h16;
  localparam logic [6:0] MINUTE_RESET = 7'h20;
  localparam logic [5:0] HOUR_NOON    = 6'h12;
  localparam logic [5:0] HOUR_LAST    = 6'h23;
  localparam logic [5:0] HOUR_NINE    = 6'h09;
  localparam logic [5:0] HOUR_NINETEEN = 6'h19;

  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] minute;
    logic       edit;
    logic [1:0] position;
    logic       pm;
    logic       blink;
    logic       daily;
    logic       hourly;
    logic [5:0] chime;
  } alrm_state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] tone;
    logic       leave;
  } alrm_flags_t;

  function automatic logic [5:0] bcd_to_bin(input logic [5:0] b);
    bcd_to_bin = 6'({2'b00, b[5:4]} * 6'd10) + {2'b00, b[3:0]};
  endfunction

  // Values stay below 64, so the tens digit comes from a short compare chain.
  function automatic logic [5:0] bin_to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    if (v >= 6'd60) begin
      tens = 3'd6;
    end else if (v >= 6'd50) begin
      tens = 3'd5;
    end else if (v >= 6'd40) begin
      tens = 3'd4;
    end else if (v >= 6'd30) begin
      tens = 3'd3;
    end else if (v >= 6'd20) begin
      tens = 3'd2;
    end else if (v >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    ones = v - 6'({3'b000, tens} * 6'd10);
    bin_to_bcd = {tens[1:0], ones[3:0]};
  endfunction

  function automatic logic [5:0] next_chime_hour(input logic [5:0] now);
    if (now == HOUR_LAST) begin
      next_chime_hour = 6'h00;
    end else if (now == HOUR_NINE) begin
      next_chime_hour = 6'h10;
    end else if (now == HOUR_NINETEEN) begin
      next_chime_hour = 6'h20;
    end else begin
      next_chime_hour = now + 6'd1;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/alrm_step.sv]
// Combinational update of the alarm state for one event word.
`default_nettype none

module alrm_step
  import alrm_pkg::*;
(
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  key_code,
  input  wire logic [5:0]  now_hour,
  input  wire alrm_state_t state_cur,
  output alrm_state_t      state_nxt,
  output alrm_flags_t      flags
);

  logic [3:0] digit;
  logic       is_digit;

  assign is_digit = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
  assign digit    = 4'(key_code - KEY_ZERO);

  always_comb begin
    state_nxt     = state_cur;
    flags.command = CMD_NONE;
    flags.tone    = TONE_SILENT;
    flags.leave   = 1'b0;
    if (action == ACT_CHIME) begin
      flags.tone      = TONE_CHIME;
      state_nxt.chime = next_chime_hour(now_hour);
      flags.command   = CMD_ARM_CHIME;
    end else if (action == ACT_DAILY) begin
      flags.tone    = TONE_ALARM;
      flags.command = CMD_ARM_DAILY;
    end else if (!state_cur.edit) begin
      case (action)
        ACT_KEY: begin
          if (key_code == KEY_STAR) begin
            if (state_cur.hourly) begin
              state_nxt.hourly = 1'b0;
              flags.command    = CMD_CANCEL_CHIME;
            end else begin
              state_nxt.hourly = 1'b1;
              state_nxt.chime  = next_chime_hour(now_hour);
              flags.command    = CMD_ARM_CHIME;
            end
          end else if (key_code == KEY_FOUR) begin
            state_nxt.daily = ~state_cur.daily;
            flags.command   = state_cur.daily ? CMD_CANCEL_DAILY : CMD_ARM_DAILY;
          end
        end
        ACT_MODE: begin
          flags.leave = 1'b1;
        end
        ACT_ADJUST: begin
          state_nxt.edit     = 1'b1;
          state_nxt.blink    = 1'b1;
          state_nxt.position = 2'd0;
          if (state_cur.hour == 6'h00) begin
            state_nxt.hour = HOUR_NOON;
            state_nxt.pm   = 1'b0;
          end else if (state_cur.hour == HOUR_NOON) begin
            state_nxt.pm = 1'b1;
          end else if (state_cur.hour > HOUR_NOON) begin
            state_nxt.hour = bin_to_bcd(bcd_to_bin(state_cur.hour) - 6'd12);
            state_nxt.pm   = 1'b1;
          end else begin
            state_nxt.pm = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (action)
        ACT_BLINK: begin
          state_nxt.blink = ~state_cur.blink;
        end
        ACT_KEY: begin
          if (is_digit) begin
            case (state_cur.position)
              2'd0: begin
                if (digit == 4'd0) begin
                  state_nxt.hour     = {2'b00, state_cur.hour[3:0]};
                  state_nxt.position = 2'd1;
                end else if (digit == 4'd1) begin
                  if (state_cur.hour[3:0] > 4'd2) begin
                    state_nxt.hour = 6'h10;
                  end else begin
                    state_nxt.hour = {2'b01, state_cur.hour[3:0]};
                  end
                  state_nxt.position = 2'd1;
                end
              end
              2'd1: begin
                if ((state_cur.hour[5:4] != 2'd1) || (digit < 4'd3)) begin
                  state_nxt.hour     = {state_cur.hour[5:4], digit};
                  state_nxt.position = 2'd2;
                end
              end
              2'd2: begin
                if (digit < 4'd6) begin
                  state_nxt.minute   = {digit[2:0], state_cur.minute[3:0]};
                  state_nxt.position = 2'd3;
                end
              end
              default: begin
                state_nxt.minute   = {state_cur.minute[6:4], digit};
                state_nxt.position = 2'd0;
              end
            endcase
          end else if (key_code == KEY_DOT) begin
            state_nxt.pm = ~state_cur.pm;
          end
        end
        ACT_MODE: begin
          state_nxt.position = state_cur.position + 2'd1;
        end
        ACT_ADJUST: begin
          if (state_cur.pm) begin
            if (state_cur.hour != HOUR_NOON) begin
              state_nxt.hour = bin_to_bcd(bcd_to_bin(state_cur.hour) + 6'd12);
            end
          end else if (state_cur.hour == HOUR_NOON) begin
            state_nxt.hour = 6'h00;
          end
          if (state_cur.daily) begin
            flags.command = CMD_REPLACE;
          end
          state_nxt.edit = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/bcd_alarm_set_controller.sv]
// Top level of the watch alarm controller: input register, state and result register.
//
//   channel  dir  width  contents
//   in_      in   3+16   tuser: action; tdata: key_code, now_hour
//   out_     out  32     tdata: alarm time, edit state, enables, chime hour, command, tone
//
// One event word is accepted per cycle while no stall holds it back; the word is captured
// in the input register, which feeds the update logic that writes the state and the result
// register in the same cycle. When the result register is held by a stall, the input
// register holds too and in_tready falls once it is full.
// Reset loads the alarm time 16:20 and clears the enables and edit state.
`default_nettype none

module bcd_alarm_set_controller
  import alrm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // key_code[7:0], now_hour[13:8], zero fill
  input  wire logic [2:0]  in_tuser,   // action[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // alarm_hour[5:0], alarm_minute[12:6], editing[13],
                                       // digit_position[15:14], pm_flag[16],
                                       // blink_phase[17], daily_on[18], hourly_on[19],
                                       // chime_hour[25:20], command[28:26], tone[30:29],
                                       // leave_mode[31]
);

  logic        in_valid_r;
  logic [2:0]  action_r;
  logic [7:0]  key_r;
  logic [5:0]  now_r;
  alrm_state_t state_r;
  alrm_state_t state_nxt;
  alrm_flags_t flags;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      action_r <= in_tuser;
      key_r    <= in_tdata[7:0];
      now_r    <= in_tdata[13:8];
    end
  end

  alrm_step u_step (
    .action    (action_r),
    .key_code  (key_r),
    .now_hour  (now_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .flags     (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.hour     <= HOUR_RESET;
      state_r.minute   <= MINUTE_RESET;
      state_r.edit     <= 1'b0;
      state_r.position <= 2'd0;
      state_r.pm       <= 1'b0;
      state_r.blink    <= 1'b0;
      state_r.daily    <= 1'b0;
      state_r.hourly   <= 1'b0;
      state_r.chime    <= 6'h00;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {flags.leave, flags.tone, flags.command, state_nxt.chime,
                     state_nxt.hourly, state_nxt.daily, state_nxt.blink, state_nxt.pm,
                     state_nxt.position, state_nxt.edit, state_nxt.minute,
                     state_nxt.hour};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
